/* rtl/scl_pkg.sv */
// Shared types, token codes and character classing for the source character lexer.
// Pure package: no dependencies. Used by source_char_lexer_top.
`default_nettype none

package scl_pkg;

   // Field widths and sizes
   localparam int POS_BITS      = 16;
   localparam int KEYWORD_CHARS = 8;
   localparam int KIND_BITS     = 6;
   localparam int LEN_BITS      = 8;
   localparam int CHAR_BITS     = 8;
   localparam int MAX_TOKENS    = 3;
   localparam int NUM_CAND      = 6;
   localparam int CNT_BITS      = $clog2(MAX_TOKENS + 1);
   localparam int RD_BITS       = $clog2(MAX_TOKENS);
   localparam int REQ_DATA_BITS = 8;
   localparam int RSP_DATA_BITS = 32;
   localparam int RSP_PAD_BITS  = RSP_DATA_BITS - KIND_BITS - POS_BITS - LEN_BITS;

   typedef logic [KIND_BITS-1:0] kind_type;
   typedef logic [CHAR_BITS-1:0] char_type;
   typedef logic [LEN_BITS-1:0]  len_type;
   typedef logic [POS_BITS-1:0]  pos_type;
   typedef logic [KEYWORD_CHARS-1:0][CHAR_BITS-1:0] head_type;

   // One result transaction
   typedef struct packed {
      kind_type kind;
      pos_type  pos;
      len_type  len;
      logic     run_end;
   } token_type;

   // Token kinds
   localparam kind_type KIND_NUMBER   = 6'd0;
   localparam kind_type KIND_STRING   = 6'd1;
   localparam kind_type KIND_TRUE     = 6'd2;
   localparam kind_type KIND_FALSE    = 6'd3;
   localparam kind_type KIND_LPAREN   = 6'd4;
   localparam kind_type KIND_RPAREN   = 6'd5;
   localparam kind_type KIND_LBRACE   = 6'd6;
   localparam kind_type KIND_RBRACE   = 6'd7;
   localparam kind_type KIND_LBRACKET = 6'd8;
   localparam kind_type KIND_RBRACKET = 6'd9;
   localparam kind_type KIND_SEMI     = 6'd10;
   localparam kind_type KIND_DOT      = 6'd11;
   localparam kind_type KIND_IDENT    = 6'd12;
   localparam kind_type KIND_IF       = 6'd13;
   localparam kind_type KIND_ELSEIF   = 6'd14;
   localparam kind_type KIND_ELSE     = 6'd15;
   localparam kind_type KIND_FOR      = 6'd16;
   localparam kind_type KIND_WHILE    = 6'd17;
   localparam kind_type KIND_SWITCH   = 6'd18;
   localparam kind_type KIND_CASE     = 6'd19;
   localparam kind_type KIND_BREAK    = 6'd20;
   localparam kind_type KIND_CONTINUE = 6'd21;
   localparam kind_type KIND_RETURN   = 6'd22;
   localparam kind_type KIND_VAR      = 6'd23;
   localparam kind_type KIND_TYPENAME = 6'd24;
   localparam kind_type KIND_CONST    = 6'd25;
   localparam kind_type KIND_GLOBAL   = 6'd26;
   localparam kind_type KIND_ASSIGN   = 6'd27;
   localparam kind_type KIND_PLUS     = 6'd28;
   localparam kind_type KIND_MINUS    = 6'd29;
   localparam kind_type KIND_STAR     = 6'd30;
   localparam kind_type KIND_SLASH    = 6'd31;
   localparam kind_type KIND_PERCENT  = 6'd32;
   localparam kind_type KIND_PLUS_EQ  = 6'd33;
   localparam kind_type KIND_MINUS_EQ = 6'd34;
   localparam kind_type KIND_STAR_EQ  = 6'd35;
   localparam kind_type KIND_SLASH_EQ = 6'd36;
   localparam kind_type KIND_PCT_EQ   = 6'd37;
   localparam kind_type KIND_INC      = 6'd38;
   localparam kind_type KIND_DEC      = 6'd39;
   localparam kind_type KIND_EQ       = 6'd40;
   localparam kind_type KIND_NE       = 6'd41;
   localparam kind_type KIND_GT       = 6'd42;
   localparam kind_type KIND_LT       = 6'd43;
   localparam kind_type KIND_GE       = 6'd44;
   localparam kind_type KIND_LE       = 6'd45;
   localparam kind_type KIND_LAND     = 6'd46;
   localparam kind_type KIND_LOR      = 6'd47;
   localparam kind_type KIND_NOT      = 6'd48;
   localparam kind_type KIND_AND      = 6'd49;
   localparam kind_type KIND_OR       = 6'd50;
   localparam kind_type KIND_XOR      = 6'd51;
   localparam kind_type KIND_TILDE    = 6'd52;
   localparam kind_type KIND_SHL      = 6'd53;
   localparam kind_type KIND_SHR      = 6'd54;
   localparam kind_type KIND_EOF      = 6'd55;
   localparam kind_type KIND_DEFAULT  = 6'd56;
   localparam kind_type KIND_COMMA    = 6'd57;
   localparam kind_type KIND_UNKNOWN  = 6'd58;

   localparam len_type LEN_MAX = '1;

   // Saturating length increment
   function automatic len_type sat_inc(input len_type v);
      return (v == LEN_MAX) ? LEN_MAX : len_type'(v + 1'b1);
   endfunction

   function automatic logic is_quote(input char_type c);
      return (c == "\"") || (c == "'");
   endfunction

   function automatic logic is_space(input char_type c);
      return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
   endfunction

   function automatic logic is_digit(input char_type c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_word_char(input char_type c);
      return is_digit(c) || ((c >= "a") && (c <= "z")) ||
             ((c >= "A") && (c <= "Z")) || (c == "_");
   endfunction

   // Operator characters that may open a two-character operator
   function automatic logic starts_pair(input char_type c);
      return (c == "+") || (c == "-") || (c == "*") || (c == "/") || (c == "%") ||
             (c == "=") || (c == "!") || (c == ">") || (c == "<") || (c == "&") ||
             (c == "|");
   endfunction

   function automatic kind_type single_op(input char_type c);
      kind_type k;
      unique case (c)
         "=":     k = KIND_ASSIGN;
         "+":     k = KIND_PLUS;
         "-":     k = KIND_MINUS;
         "*":     k = KIND_STAR;
         "/":     k = KIND_SLASH;
         "%":     k = KIND_PERCENT;
         ">":     k = KIND_GT;
         "<":     k = KIND_LT;
         "!":     k = KIND_NOT;
         "&":     k = KIND_AND;
         "|":     k = KIND_OR;
         "^":     k = KIND_XOR;
         "~":     k = KIND_TILDE;
         default: k = KIND_UNKNOWN;
      endcase
      return k;
   endfunction

   // Punctuation: returns hit flag in the top bit, kind below
   function automatic logic [KIND_BITS:0] punct(input char_type c);
      logic [KIND_BITS:0] r;
      unique case (c)
         "(":     r = {1'b1, KIND_LPAREN};
         ")":     r = {1'b1, KIND_RPAREN};
         "{":     r = {1'b1, KIND_LBRACE};
         "}":     r = {1'b1, KIND_RBRACE};
         "[":     r = {1'b1, KIND_LBRACKET};
         "]":     r = {1'b1, KIND_RBRACKET};
         ";":     r = {1'b1, KIND_SEMI};
         ".":     r = {1'b1, KIND_DOT};
         ",":     r = {1'b1, KIND_COMMA};
         default: r = {1'b0, KIND_UNKNOWN};
      endcase
      return r;
   endfunction

   // Two-character operator: returns hit flag in the top bit, kind below
   function automatic logic [KIND_BITS:0] pair_op(input char_type a, input char_type b);
      logic [KIND_BITS:0] r;
      r = {1'b0, KIND_UNKNOWN};
      if (b == "=") begin
         unique case (a)
            "+":     r = {1'b1, KIND_PLUS_EQ};
            "-":     r = {1'b1, KIND_MINUS_EQ};
            "*":     r = {1'b1, KIND_STAR_EQ};
            "/":     r = {1'b1, KIND_SLASH_EQ};
            "%":     r = {1'b1, KIND_PCT_EQ};
            "=":     r = {1'b1, KIND_EQ};
            "!":     r = {1'b1, KIND_NE};
            ">":     r = {1'b1, KIND_GE};
            "<":     r = {1'b1, KIND_LE};
            default: r = {1'b0, KIND_UNKNOWN};
         endcase
      end else if (a == b) begin
         unique case (a)
            "+":     r = {1'b1, KIND_INC};
            "-":     r = {1'b1, KIND_DEC};
            "&":     r = {1'b1, KIND_LAND};
            "|":     r = {1'b1, KIND_LOR};
            "<":     r = {1'b1, KIND_SHL};
            ">":     r = {1'b1, KIND_SHR};
            default: r = {1'b0, KIND_UNKNOWN};
         endcase
      end
      return r;
   endfunction

   // Compare word head against a right-justified literal of len characters
   function automatic logic kw_is(input head_type head, input len_type count,
                                  input logic [63:0] text, input int len);
      logic hit;
      hit = (count == len_type'(len)) && (len <= KEYWORD_CHARS);
      for (int i = 0; i < KEYWORD_CHARS; i++) begin
         if ((i < len) && (head[i] != text[8*(len-1-i) +: 8]))
            hit = 1'b0;
      end
      return hit;
   endfunction

   // Word classification, in priority order
   function automatic kind_type classify(input head_type head, input len_type count,
                                         input logic digits_only);
      kind_type k;
      priority if (kw_is(head, count, "var", 3))      k = KIND_VAR;
      else if (kw_is(head, count, "const", 5))        k = KIND_CONST;
      else if (kw_is(head, count, "global", 6))       k = KIND_GLOBAL;
      else if (kw_is(head, count, "number", 6) || kw_is(head, count, "string", 6) ||
               kw_is(head, count, "bool", 4))         k = KIND_TYPENAME;
      else if (digits_only && (count != '0))          k = KIND_NUMBER;
      else if (kw_is(head, count, "if", 2))           k = KIND_IF;
      else if (kw_is(head, count, "elseif", 6))       k = KIND_ELSEIF;
      else if (kw_is(head, count, "else", 4))         k = KIND_ELSE;
      else if (kw_is(head, count, "for", 3))          k = KIND_FOR;
      else if (kw_is(head, count, "while", 5))        k = KIND_WHILE;
      else if (kw_is(head, count, "switch", 6))       k = KIND_SWITCH;
      else if (kw_is(head, count, "case", 4))         k = KIND_CASE;
      else if (kw_is(head, count, "default", 7))      k = KIND_DEFAULT;
      else if (kw_is(head, count, "break", 5))        k = KIND_BREAK;
      else if (kw_is(head, count, "continue", 8))     k = KIND_CONTINUE;
      else if (kw_is(head, count, "return", 6))       k = KIND_RETURN;
      else if (kw_is(head, count, "true", 4))         k = KIND_TRUE;
      else if (kw_is(head, count, "false", 5))        k = KIND_FALSE;
      else                                            k = KIND_IDENT;
      return k;
   endfunction

endpackage

`default_nettype wire

/* rtl/source_char_lexer_top.sv */
// Source character lexer: one character in, up to three tokens out per transaction.
// Depends on scl_pkg for token codes, character classing and word classification.
//
// Usage notes
//  - req channel: one character per transaction in req_tdata[7:0]; req_tlast marks
//    the last character of a source, which flushes the pending word, emits the
//    end token and returns the lexer to its reset state.
//  - rsp channel: one token per transaction: kind, position and length in rsp_tdata;
//    rsp_tlast marks the last token caused by one character.
//  - Output: the tokens of a character are registered and appear in the cycle after it is accepted.
//  - Throughput: one character per cycle while each character yields at most one
//    token and rsp_tready stays high. A character yielding more holds req_tready
//    low while the three-entry token buffer drains one token per cycle.
//  - The next character is accepted in the cycle the last buffered token leaves,
//    so the two sides never idle on each other.
//  - A stalled rsp side holds the buffered tokens steady and back-pressures req.
//  - Reset (synchronous, active high) empties the token buffer and clears the word,
//    string, held operator and position state.
`default_nettype none

module source_char_lexer_top
   import scl_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,   // [7:0] ch
   input  wire logic                     req_tlast,   // final_char
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0]      rsp_tdata,   // [5:0] token_kind, [21:6] token_pos,
                                                      // [29:22] token_len, [31:30] zero
   output logic                          rsp_tlast    // run_end
);

   // Lexer state
   head_type             head_ff, head_in;
   len_type              word_count_ff, word_count_in;
   logic                 digits_ff, digits_in;
   logic                 in_quote_ff, in_quote_in;
   len_type              quote_count_ff, quote_count_in;
   logic                 held_valid_ff, held_valid_in;
   char_type             held_char_ff, held_char_in;
   pos_type              char_index_ff, char_index_in;

   // Token buffer
   token_type            res_ff [MAX_TOKENS];
   token_type            slot_in [MAX_TOKENS];
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in, n_new;
   logic [RD_BITS-1:0]   rd_ff, rd_in;

   // Datapath signals
   char_type             ch;
   logic                 last, req_fire, rsp_fire;
   pos_type              pos, hpos, endp;
   logic [KIND_BITS:0]   pair_r, punct_r;
   logic                 take, quote_path, in_str, plain, other, word_ext, breaker, hold;
   len_type              count_upd, count_after;
   logic                 digits_upd;
   kind_type             word_kind;
   token_type            cand [NUM_CAND];
   logic [NUM_CAND-1:0]  cand_valid;

   assign ch       = req_tdata[CHAR_BITS-1:0];
   assign last     = req_tlast;
   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;

   // Accept when the buffer is empty or its last token leaves this cycle
   assign req_tready = (cnt_ff == '0) || ((cnt_ff == CNT_BITS'(1)) && rsp_tready);

   assign pos  = char_index_ff;
   assign hpos = pos_type'(pos - 1'b1);
   assign endp = pos_type'(pos + 1'b1);

   // Classify the incoming character against the held operator and current state
   always_comb begin
      pair_r     = pair_op(held_char_ff, ch);
      punct_r    = punct(ch);
      take       = !(held_valid_ff && pair_r[KIND_BITS]);
      quote_path = take && is_quote(ch);
      in_str     = take && !is_quote(ch) && in_quote_ff;
      plain      = take && !is_quote(ch) && !in_quote_ff;
      word_ext   = plain && is_word_char(ch);
      other      = plain && !is_space(ch) && !is_word_char(ch);
      breaker    = plain && (is_space(ch) || !is_word_char(ch));
      hold       = other && !punct_r[KIND_BITS] && starts_pair(ch) && !last;
   end

   // Extend the word with the incoming character
   always_comb begin
      for (int i = 0; i < KEYWORD_CHARS; i++)
         head_in[i] = (word_ext && (word_count_ff == len_type'(i))) ? ch : head_ff[i];
      count_upd   = word_ext ? sat_inc(word_count_ff) : word_count_ff;
      digits_upd  = digits_ff && !(word_ext && !is_digit(ch));
      count_after = breaker ? '0 : count_upd;
      word_kind   = classify(head_in, count_upd, digits_upd);
   end

   // Candidate tokens in emission order
   always_comb begin
      // held operator, paired or single
      cand_valid[0] = held_valid_ff;
      cand[0].kind  = pair_r[KIND_BITS] ? pair_r[KIND_BITS-1:0] : single_op(held_char_ff);
      cand[0].pos   = hpos;
      cand[0].len   = pair_r[KIND_BITS] ? len_type'(2) : len_type'(1);
      // closing quote ends a string
      cand_valid[1] = quote_path && in_quote_ff;
      cand[1].kind  = KIND_STRING;
      cand[1].pos   = pos;
      cand[1].len   = sat_inc(quote_count_ff);
      // word ended by whitespace or a symbol
      cand_valid[2] = breaker && (word_count_ff != '0);
      cand[2].kind  = word_kind;
      cand[2].pos   = pos;
      cand[2].len   = word_count_ff;
      // punctuation or single operator
      cand_valid[3] = other && !hold;
      cand[3].kind  = punct_r[KIND_BITS] ? punct_r[KIND_BITS-1:0] : single_op(ch);
      cand[3].pos   = pos;
      cand[3].len   = len_type'(1);
      // word flushed at end of source
      cand_valid[4] = last && (count_after != '0);
      cand[4].kind  = word_kind;
      cand[4].pos   = endp;
      cand[4].len   = count_upd;
      // end of source
      cand_valid[5] = last;
      cand[5].kind  = KIND_EOF;
      cand[5].pos   = endp;
      cand[5].len   = '0;
      for (int i = 0; i < NUM_CAND; i++)
         cand[i].run_end = 1'b0;
   end

   // Pack valid candidates into the buffer slots, dropping any beyond capacity
   always_comb begin
      n_new = '0;
      for (int k = 0; k < MAX_TOKENS; k++)
         slot_in[k] = '0;
      for (int i = 0; i < NUM_CAND; i++) begin
         if (cand_valid[i] && (n_new != CNT_BITS'(MAX_TOKENS))) begin
            slot_in[n_new[RD_BITS-1:0]] = cand[i];
            n_new = CNT_BITS'(n_new + 1'b1);
         end
      end
      if (n_new != '0)
         slot_in[RD_BITS'(n_new - 1'b1)].run_end = 1'b1;
   end

   // Next lexer state
   always_comb begin
      if (last) begin
         word_count_in  = '0;
         digits_in      = 1'b1;
         in_quote_in    = 1'b0;
         quote_count_in = '0;
         held_valid_in  = 1'b0;
         char_index_in  = '0;
      end else begin
         word_count_in  = count_after;
         digits_in      = breaker ? 1'b1 : digits_upd;
         in_quote_in    = quote_path ? !in_quote_ff : in_quote_ff;
         quote_count_in = quote_path ? (in_quote_ff ? len_type'(0) : len_type'(1)) :
                          in_str     ? sat_inc(quote_count_ff) : quote_count_ff;
         held_valid_in  = hold;
         char_index_in  = endp;
      end
      held_char_in = hold ? ch : held_char_ff;
   end

   // Buffer pointers: load on accept, advance on each delivered token
   always_comb begin
      cnt_in = cnt_ff;
      rd_in  = rd_ff;
      if (req_fire) begin
         cnt_in = n_new;
         rd_in  = '0;
      end else if (rsp_fire) begin
         cnt_in = CNT_BITS'(cnt_ff - 1'b1);
         rd_in  = RD_BITS'(rd_ff + 1'b1);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         word_count_ff  <= '0;
         digits_ff      <= 1'b1;
         in_quote_ff    <= 1'b0;
         quote_count_ff <= '0;
         held_valid_ff  <= 1'b0;
         char_index_ff  <= '0;
         cnt_ff         <= '0;
         rd_ff          <= '0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
         if (req_fire) begin
            word_count_ff  <= word_count_in;
            digits_ff      <= digits_in;
            in_quote_ff    <= in_quote_in;
            quote_count_ff <= quote_count_in;
            held_valid_ff  <= held_valid_in;
            char_index_ff  <= char_index_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         head_ff      <= head_in;
         held_char_ff <= held_char_in;
         for (int k = 0; k < MAX_TOKENS; k++)
            res_ff[k] <= slot_in[k];
      end
   end

   // Present the token at the read pointer
   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_tdata  = {{RSP_PAD_BITS{1'b0}}, res_ff[rd_ff].len, res_ff[rd_ff].pos,
                        res_ff[rd_ff].kind};
   assign rsp_tlast  = res_ff[rd_ff].run_end;

endmodule

`default_nettype wire

/* verif/tb_source_char_lexer_top.sv */
// Self-checking testbench for source_char_lexer_top: streams characters in, checks tokens out.
// Depends on scl_pkg for token codes and the result layout; predicts each token no row types in.
// Directed rows first, then a keyword sweep and random sources.

module tb_source_char_lexer_top;
   timeunit 1ns;
   timeprecision 1ps;
   import scl_pkg::*;

   localparam int CYCLE_LIMIT  = 50_000;
   localparam int TOTAL_ITEMS  = 170;
   localparam int NUM_KEYWORDS = 19;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;   // [7:0] ch
   logic                     req_tlast  = 1'b0; // final_char
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;         // [5:0] kind, [21:6] pos, [29:22] len
   logic                     rsp_tlast;         // run_end

   source_char_lexer_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // Lexer state mirrored by the token predictor
   char_type  word_buf [KEYWORD_CHARS];
   len_type   word_len   = '0;
   logic      all_digits = 1'b1;
   logic      quoting    = 1'b0;
   len_type   str_len    = '0;
   logic      op_pending = 1'b0;
   char_type  op_char    = '0;
   pos_type   cursor     = '0;

   token_type fresh [$];       // tokens of the character just accepted
   token_type tokens_due [$];  // tokens still owed by the lexer
   char_type  src [$];         // source text waiting to be sent

   int        idle_pct   = 20;
   int        errors     = 0;
   int        cycles     = 0;
   int        sent_items = 0;
   logic      req_fire   = 1'b0;
   logic      typed_due  = 1'b0;
   token_type typed_tok  = '0;

   // Directed rows: character, final flag, and a typed-in token where one is obvious
   typedef struct packed {
      char_type c;
      logic     last;
      logic     typed;
      kind_type kind;
      pos_type  pos;
      len_type  len;
   } row_type;

   row_type script [25] = '{
      '{"i",   1'b0, 1'b0, KIND_UNKNOWN, 16'd0,  8'd0},
      '{"f",   1'b0, 1'b0, KIND_UNKNOWN, 16'd0,  8'd0},
      '{" ",   1'b0, 1'b1, KIND_IF,      16'd2,  8'd2},
      '{"(",   1'b0, 1'b1, KIND_LPAREN,  16'd3,  8'd1},
      '{8'h00, 1'b0, 1'b1, KIND_UNKNOWN, 16'd4,  8'd1},
      '{8'hFF, 1'b0, 1'b1, KIND_UNKNOWN, 16'd5,  8'd1},
      '{"+",   1'b0, 1'b0, KIND_UNKNOWN, 16'd0,  8'd0},
      '{"=",   1'b0, 1'b1, KIND_PLUS_EQ, 16'd6,  8'd2},
      '{"<",   1'b0, 1'b0, KIND_UNKNOWN, 16'd0,  8'd0},
      '{"x",   1'b0, 1'b1, KIND_LT,      16'd8,  8'd1},
      '{"'",   1'b0, 1'b0, KIND_UNKNOWN, 16'd0,  8'd0},
      '{"a",   1'b0, 1'b0, KIND_UNKNOWN, 16'd0,  8'd0},
      '{"\"",  1'b0, 1'b1, KIND_STRING,  16'd12, 8'd3},
      '{"7",   1'b0, 1'b0, KIND_UNKNOWN, 16'd0,  8'd0},
      '{"=",   1'b0, 1'b1, KIND_IDENT,   16'd14, 8'd2},
      '{"=",   1'b0, 1'b1, KIND_EQ,      16'd14, 8'd2},
      '{"\"",  1'b0, 1'b0, KIND_UNKNOWN, 16'd0,  8'd0},
      '{"q",   1'b0, 1'b0, KIND_UNKNOWN, 16'd0,  8'd0},
      '{"-",   1'b1, 1'b1, KIND_EOF,     16'd19, 8'd0},
      '{"9",   1'b0, 1'b0, KIND_UNKNOWN, 16'd0,  8'd0},
      '{"9",   1'b0, 1'b0, KIND_UNKNOWN, 16'd0,  8'd0},
      '{"!",   1'b1, 1'b0, KIND_UNKNOWN, 16'd0,  8'd0},
      '{8'h09, 1'b1, 1'b1, KIND_EOF,     16'd1,  8'd0},
      '{"-",   1'b0, 1'b0, KIND_UNKNOWN, 16'd0,  8'd0},
      '{"-",   1'b1, 1'b0, KIND_UNKNOWN, 16'd0,  8'd0}
   };

   // Keywords first (random part relies on it), then operators, punctuation, strings, other words
   string vocab [$] = '{
      "var", "const", "global", "number", "string", "bool", "if", "elseif", "else",
      "for", "while", "switch", "case", "default", "break", "continue", "return",
      "true", "false",
      "+", "-", "*", "/", "%", "=", "!", ">", "<", "&", "|", "^", "~",
      "+=", "-=", "*=", "/=", "%=", "==", "!=", ">=", "<=", "++", "--", "&&", "||",
      "<<", ">>",
      "(", ")", "{", "}", "[", "]", ";", ".", ",",
      "'s q'", "\"it\"", "'mix\"", "_", "x_1", "0", "255", "continues", "Var"
   };

   function automatic len_type bump(input len_type v);
      return (v == '1) ? v : len_type'(v + 1'b1);
   endfunction

   function automatic void note(input kind_type k, input pos_type p, input len_type n);
      token_type t;
      if (fresh.size() < MAX_TOKENS) begin
         t.kind    = k;
         t.pos     = p;
         t.len     = n;
         t.run_end = 1'b0;
         fresh.push_back(t);
      end
   endfunction

   function automatic kind_type word_kind();
      string text;
      text = "";
      if (all_digits) return KIND_NUMBER;
      if (word_len > KEYWORD_CHARS) return KIND_IDENT;
      for (int i = 0; i < word_len; i++) text = $sformatf("%s%c", text, word_buf[i]);
      case (text)
         "var":                      return KIND_VAR;
         "const":                    return KIND_CONST;
         "global":                   return KIND_GLOBAL;
         "number", "string", "bool": return KIND_TYPENAME;
         "if":                       return KIND_IF;
         "elseif":                   return KIND_ELSEIF;
         "else":                     return KIND_ELSE;
         "for":                      return KIND_FOR;
         "while":                    return KIND_WHILE;
         "switch":                   return KIND_SWITCH;
         "case":                     return KIND_CASE;
         "default":                  return KIND_DEFAULT;
         "break":                    return KIND_BREAK;
         "continue":                 return KIND_CONTINUE;
         "return":                   return KIND_RETURN;
         "true":                     return KIND_TRUE;
         "false":                    return KIND_FALSE;
         default:                    return KIND_IDENT;
      endcase
   endfunction

   function automatic kind_type lone_op(input char_type c);
      case (c)
         "=":     return KIND_ASSIGN;
         "+":     return KIND_PLUS;
         "-":     return KIND_MINUS;
         "*":     return KIND_STAR;
         "/":     return KIND_SLASH;
         "%":     return KIND_PERCENT;
         ">":     return KIND_GT;
         "<":     return KIND_LT;
         "!":     return KIND_NOT;
         "&":     return KIND_AND;
         "|":     return KIND_OR;
         "^":     return KIND_XOR;
         "~":     return KIND_TILDE;
         default: return KIND_UNKNOWN;
      endcase
   endfunction

   // Unknown stands for no pair, since no pair ever yields it
   function automatic kind_type paired_kind(input char_type a, input char_type b);
      case ({a, b})
         "+=":    return KIND_PLUS_EQ;
         "-=":    return KIND_MINUS_EQ;
         "*=":    return KIND_STAR_EQ;
         "/=":    return KIND_SLASH_EQ;
         "%=":    return KIND_PCT_EQ;
         "==":    return KIND_EQ;
         "!=":    return KIND_NE;
         ">=":    return KIND_GE;
         "<=":    return KIND_LE;
         "++":    return KIND_INC;
         "--":    return KIND_DEC;
         "&&":    return KIND_LAND;
         "||":    return KIND_LOR;
         "<<":    return KIND_SHL;
         ">>":    return KIND_SHR;
         default: return KIND_UNKNOWN;
      endcase
   endfunction

   function automatic kind_type punct_kind(input char_type c);
      case (c)
         "(":     return KIND_LPAREN;
         ")":     return KIND_RPAREN;
         "{":     return KIND_LBRACE;
         "}":     return KIND_RBRACE;
         "[":     return KIND_LBRACKET;
         "]":     return KIND_RBRACKET;
         ";":     return KIND_SEMI;
         ".":     return KIND_DOT;
         ",":     return KIND_COMMA;
         default: return KIND_UNKNOWN;
      endcase
   endfunction

   function automatic logic is_blank(input char_type c);
      return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
   endfunction

   function automatic void close_word(input pos_type p);
      if (word_len != '0) begin
         note(word_kind(), p, word_len);
         word_len   = '0;
         all_digits = 1'b1;
      end
   endfunction

   function automatic void clear_lexer();
      word_len   = '0;
      all_digits = 1'b1;
      quoting    = 1'b0;
      str_len    = '0;
      op_pending = 1'b0;
      cursor     = '0;
   endfunction

   // One character outside a pending operator pair
   function automatic void absorb(input char_type c, input pos_type here, input logic last);
      kind_type k;
      if ((c == "\"") || (c == "'")) begin
         if (quoting) begin
            note(KIND_STRING, here, bump(str_len));
            quoting = 1'b0;
            str_len = '0;
         end else begin
            quoting = 1'b1;
            str_len = 8'd1;
         end
      end else if (quoting) begin
         str_len = bump(str_len);
      end else if (is_blank(c)) begin
         close_word(here);
      end else if (((c >= "0") && (c <= "9")) || ((c >= "a") && (c <= "z")) ||
                   ((c >= "A") && (c <= "Z")) || (c == "_")) begin
         if (word_len < KEYWORD_CHARS) word_buf[word_len] = c;
         word_len = bump(word_len);
         if ((c < "0") || (c > "9")) all_digits = 1'b0;
      end else begin
         close_word(here);
         k = punct_kind(c);
         if (k != KIND_UNKNOWN) begin
            note(k, here, 8'd1);
         end else if ((lone_op(c) != KIND_UNKNOWN) && (c != "^") && (c != "~") && !last) begin
            op_pending = 1'b1;
            op_char    = c;
         end else begin
            note(lone_op(c), here, 8'd1);
         end
      end
   endfunction

   // Predict the tokens of one accepted character into fresh
   function automatic void lex_char(input char_type c, input logic last);
      pos_type  here;
      logic     taken;
      kind_type pk;
      fresh.delete();
      here  = cursor;
      taken = 1'b0;
      if (op_pending) begin
         op_pending = 1'b0;
         pk = paired_kind(op_char, c);
         if (pk != KIND_UNKNOWN) begin
            note(pk, pos_type'(here - 1'b1), 8'd2);
            taken = 1'b1;
         end else begin
            note(lone_op(op_char), pos_type'(here - 1'b1), 8'd1);
         end
      end
      if (!taken) absorb(c, here, last);
      if (last) begin
         close_word(pos_type'(here + 1'b1));
         note(KIND_EOF, pos_type'(here + 1'b1), 8'd0);
         clear_lexer();
      end else begin
         cursor = pos_type'(here + 1'b1);
      end
      if (fresh.size() != 0) fresh[fresh.size() - 1].run_end = 1'b1;
   endfunction

   // Sample handshakes on the falling edge, where every signal is settled for the next rise
   always @(negedge clock) begin : watch
      token_type got;
      token_type want;
      req_fire = !reset && req_tvalid && req_tready;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind    = rsp_tdata[5:0];
         got.pos     = rsp_tdata[21:6];
         got.len     = rsp_tdata[29:22];
         got.run_end = rsp_tlast;
         if (tokens_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected token kind %0d pos %0d len %0d last %0b",
                     $time, got.kind, got.pos, got.len, got.run_end);
         end else begin
            want = tokens_due.pop_front();
            if (got !== want) begin
               errors++;
               $display("%0t: expected kind %0d pos %0d len %0d last %0b, %s",
                        $time, want.kind, want.pos, want.len, want.run_end,
                        $sformatf("got kind %0d pos %0d len %0d last %0b",
                                  got.kind, got.pos, got.len, got.run_end));
            end
         end
      end
      if (req_fire) begin
         lex_char(req_tdata, req_tlast);
         if (typed_due) tokens_due.push_back(typed_tok);
         else foreach (fresh[i]) tokens_due.push_back(fresh[i]);
      end
   end

   // Stall the token side at random
   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= idle_pct);

   // Give up on a hang
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("source_char_lexer_top test failed");
         $finish;
      end
   end

   // Offer one character and hold it until the transaction completes
   task automatic send_char(input char_type c, input logic last,
                            input logic typed = 1'b0, input token_type t = '0);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      typed_due = typed;
      typed_tok = t;
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      do @(posedge clock); while (!req_fire);
      sent_items++;
   endtask

   // Send the buffered source, final flag on its last character
   task automatic send_src();
      foreach (src[i]) send_char(src[i], i == src.size() - 1);
      src.delete();
   endtask

   // Hold off until every owed token has been taken
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tokens_due.size() != 0) @(posedge clock);
   endtask

   function automatic void add_word(input string w);
      for (int i = 0; i < w.len(); i++) src.push_back(w[i]);
   endfunction

   function automatic char_type word_char();
      int r;
      r = $urandom_range(62);
      if (r < 26) return char_type'("a" + r);
      if (r < 52) return char_type'("A" + r - 26);
      if (r < 62) return char_type'("0" + r - 52);
      return "_";
   endfunction

   // Printable, never a quote
   function automatic char_type plain_char();
      int r;
      r = $urandom_range(32, 124);
      if ((r == 34) || (r == 39)) r++;
      return char_type'(r);
   endfunction

   function automatic char_type quote_char();
      return $urandom_range(1) ? "'" : "\"";
   endfunction

   // Mostly well-formed code with a little noise, ended by a final character
   task automatic random_source();
      int pieces;
      int n;
      pieces = $urandom_range(1, 6);
      repeat (pieces) begin
         case ($urandom_range(9))
            4: begin
               src.push_back($urandom_range(1) ? char_type'("a" + $urandom_range(25)) : "_");
               n = $urandom_range(0, 11);
               repeat (n) src.push_back(word_char());
            end
            5: begin
               n = $urandom_range(1, 6);
               repeat (n) src.push_back(char_type'("0" + $urandom_range(9)));
            end
            6: begin
               add_word(vocab[$urandom_range(NUM_KEYWORDS - 1)]);
               src.push_back(word_char());
            end
            7: src.push_back(char_type'($urandom_range(255)));
            8: begin
               src.push_back(quote_char());
               n = $urandom_range(0, 6);
               repeat (n) src.push_back(plain_char());
               src.push_back(quote_char());
            end
            default: add_word(vocab[$urandom_range(vocab.size() - 1)]);
         endcase
         n = $urandom_range(9);
         if (n < 5) src.push_back(" ");
         else if (n < 7) src.push_back(char_type'($urandom_range(9, 13)));
      end
      send_src();
   endtask

   initial begin : stimulus
      token_type row_tok;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows
      foreach (script[i]) begin
         row_tok.kind    = script[i].kind;
         row_tok.pos     = script[i].pos;
         row_tok.len     = script[i].len;
         row_tok.run_end = 1'b1;
         send_char(script[i].c, script[i].last, script[i].typed, row_tok);
      end
      drain();

      // Every keyword once, each closed by an operator, with no stalls on either side
      idle_pct = 0;
      for (int i = 0; i < NUM_KEYWORDS; i++) begin
         add_word(vocab[i]);
         add_word(vocab[NUM_KEYWORDS + i]);
      end
      send_src();
      drain();
      idle_pct = 20;

      // Random sources
      while (sent_items < TOTAL_ITEMS) random_source();

      drain();
      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("source_char_lexer_top test passed");
      end else begin
         $display("source_char_lexer_top test failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/scl_pkg.sv
rtl/source_char_lexer_top.sv
verif/tb_source_char_lexer_top.sv
